[sv/assert_macros.svh]
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, ignored while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/hrht_pkg.sv]
// Package with phase codes, tag codes and delimiter characters of the tokenizer.
package hrht_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned TagW   = 3;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_METHOD = 3'd0;
  localparam logic [PhaseW-1:0] PH_PATH   = 3'd1;
  localparam logic [PhaseW-1:0] PH_PROTO  = 3'd2;
  localparam logic [PhaseW-1:0] PH_NAME   = 3'd3;
  localparam logic [PhaseW-1:0] PH_VALUE  = 3'd4;

  // Output tags
  localparam logic [TagW-1:0] TAG_DROP   = 3'd0;
  localparam logic [TagW-1:0] TAG_METHOD = 3'd1;
  localparam logic [TagW-1:0] TAG_PATH   = 3'd2;
  localparam logic [TagW-1:0] TAG_PROTO  = 3'd3;
  localparam logic [TagW-1:0] TAG_NAME   = 3'd4;
  localparam logic [TagW-1:0] TAG_VALUE  = 3'd5;

  // Delimiters
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

endpackage

[sv/hrht_in_if.sv]
// Request channel carrying one raw byte of the request head.
interface hrht_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink   (input valid, input in_byte, input first, output ready);
endinterface

[sv/hrht_out_if.sv]
// Result channel carrying one tagged byte.
interface hrht_out_if;
  import hrht_pkg::*;
  logic            valid;
  logic            ready;
  logic [7:0]      out_byte;
  logic [TagW-1:0] tag;
  logic            pair_end;
  logic            head_end;

  modport source (output valid, output out_byte, output tag, output pair_end,
                  output head_end, input ready);
  modport sink   (input valid, input out_byte, input tag, input pair_end,
                  input head_end, output ready);
endinterface

[sv/http_request_head_tokenizer_unit.sv]
// HTTP request head tokenizer: tags each byte as method, path, protocol, name or value, or drops it.
//
// Usage:
//  - in_i carries one byte of a request head per request, with first = 1 on the
//    byte that opens a new head (it clears the parser state).
//  - out_o returns exactly one result per input byte, in order: the byte, its
//    tag (0 dropped, 1 method, 2 path, 3 protocol, 4 name, 5 value), a pair_end
//    flag on the line feed that closes a header pair and a head_end flag on the
//    byte that stops the head.
//  - Each accepted byte passes the input register and then the result register;
//    throughput is one byte per cycle while out_o is not stalled.
//  - The input register takes a byte while a finished result waits on out_o,
//    so one extra byte is absorbed before in_i.ready drops under a stall.
//  - Reset empties both stages and puts the parser in the method phase with all
//    flags clear. After the head ends, bytes come out dropped until first = 1.
module http_request_head_tokenizer_unit
  import hrht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hrht_in_if.sink    in_i,
  hrht_out_if.source out_o
);

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;

  // Parser state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              skip_q, skip_d;
  logic              name_seen_q, name_seen_d;
  logic              value_seen_q, value_seen_d;
  logic              finished_q, finished_d;

  // Result stage
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic [TagW-1:0] out_tag_q;
  logic            out_pair_q;
  logic            out_head_q;

  logic            out_load;
  logic            s1_load;
  logic [TagW-1:0] res_tag;
  logic            res_pair;
  logic            res_head;

  logic [PhaseW-1:0] ph;
  logic              skip_now;
  logic              nseen;
  logic              vseen;
  logic              fin;

  assign out_load   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_load    = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || out_load;

  always_comb begin
    // first restarts the parser before this byte is looked at
    ph       = s1_first_q ? PH_METHOD : phase_q;
    skip_now = s1_first_q ? 1'b0 : skip_q;
    nseen    = s1_first_q ? 1'b0 : name_seen_q;
    vseen    = s1_first_q ? 1'b0 : value_seen_q;
    fin      = s1_first_q ? 1'b0 : finished_q;

    res_tag      = TAG_DROP;
    res_pair     = 1'b0;
    res_head     = 1'b0;
    phase_d      = ph;
    skip_d       = 1'b0;
    name_seen_d  = nseen;
    value_seen_d = vseen;
    finished_d   = fin;

    if (fin) begin
      // ignored until a new head
    end else if (s1_byte_q == CH_NUL) begin
      res_head   = 1'b1;
      finished_d = 1'b1;
    end else begin
      case (ph)
        PH_METHOD: begin
          if (s1_byte_q == CH_SP) phase_d = PH_PATH;
          else res_tag = TAG_METHOD;
        end
        PH_PATH: begin
          if (s1_byte_q == CH_SP) phase_d = PH_PROTO;
          else res_tag = TAG_PATH;
        end
        PH_PROTO: begin
          if (s1_byte_q == CH_LF) phase_d = PH_NAME;
          else if (s1_byte_q != CH_CR) res_tag = TAG_PROTO;
        end
        PH_NAME: begin
          if (s1_byte_q == CH_LF) begin
            res_head   = 1'b1;
            finished_d = 1'b1;
          end else if (s1_byte_q == CH_COLON) begin
            phase_d = PH_VALUE;
            skip_d  = 1'b1;
          end else if (s1_byte_q != CH_CR) begin
            res_tag     = TAG_NAME;
            name_seen_d = 1'b1;
          end
        end
        PH_VALUE: begin
          if (skip_now && s1_byte_q == CH_SP) begin
            // single space after the colon
          end else if (s1_byte_q == CH_LF) begin
            if (!nseen && !vseen) begin
              // empty pair is the blank line
              res_head   = 1'b1;
              finished_d = 1'b1;
            end else begin
              res_pair     = 1'b1;
              name_seen_d  = 1'b0;
              value_seen_d = 1'b0;
              phase_d      = PH_NAME;
            end
          end else if (s1_byte_q != CH_CR) begin
            res_tag      = TAG_VALUE;
            value_seen_d = 1'b1;
          end
        end
        default: begin
          // unused codes: drop, keep state
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_METHOD;
      skip_q       <= 1'b0;
      name_seen_q  <= 1'b0;
      value_seen_q <= 1'b0;
      finished_q   <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (out_load) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        skip_q       <= skip_d;
        name_seen_q  <= name_seen_d;
        value_seen_q <= value_seen_d;
        finished_q   <= finished_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byte_q  <= in_i.in_byte;
      s1_first_q <= in_i.first;
    end
    if (out_load) begin
      out_byte_q <= s1_byte_q;
      out_tag_q  <= res_tag;
      out_pair_q <= res_pair;
      out_head_q <= res_head;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.tag      = out_tag_q;
  assign out_o.pair_end = out_pair_q;
  assign out_o.head_end = out_head_q;

  `include "assert_macros.svh"

  `ASSERT_CLK(a_pair_head_excl, out_valid_q |-> !(out_pair_q && out_head_q), "pair_end and head_end together")
  `ASSERT_CLK(a_head_sets_fin, (out_load && res_head) |=> finished_q, "head end did not set finished")
  `ASSERT_CLK(a_fin_drops, (out_load && finished_q && !s1_first_q) |=> (out_tag_q == TAG_DROP && !out_pair_q && !out_head_q), "byte after head end not dropped")
  `ASSERT_CLK(a_phase_range, phase_q <= PH_VALUE, "phase out of range")
  `ASSERT_CLK(a_stall_keeps, (s1_valid_q && !out_load) |=> s1_valid_q, "input stage lost a byte")

endmodule

[dv/tb_top.sv]
// Testbench for the HTTP request head tokenizer: random heads, stalls and a scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import hrht_pkg::*;

  typedef struct packed {
    logic [7:0]      data;
    logic [TagW-1:0] tag;
    logic            pair_end;
    logic            head_end;
  } token_t;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_e;

  class head_token_scoreboard;
    logic [PhaseW-1:0] phase;
    bit                skip_space;
    bit                name_seen;
    bit                value_seen;
    bit                done;
    token_t            expected_q[$];
    int unsigned       n_checked;
    int unsigned       n_errors;
    int unsigned       n_pairs;
    int unsigned       n_heads;

    function new();
      clear_state();
      n_checked = 0;
      n_errors  = 0;
      n_pairs   = 0;
      n_heads   = 0;
    endfunction

    function void clear_state();
      phase      = PH_METHOD;
      skip_space = 1'b0;
      name_seen  = 1'b0;
      value_seen = 1'b0;
      done       = 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Work out the token for one accepted request byte.
    function void note_byte(logic [7:0] b, logic f);
      token_t t;
      bit     skip_now;
      t.data     = b;
      t.tag      = TAG_DROP;
      t.pair_end = 1'b0;
      t.head_end = 1'b0;
      if (f) clear_state();
      skip_now   = skip_space;
      skip_space = 1'b0;
      if (done) begin
        // ignored until a new head
      end else if (b == CH_NUL) begin
        t.head_end = 1'b1;
        done       = 1'b1;
      end else begin
        case (phase)
          PH_METHOD: begin
            if (b == CH_SP) phase = PH_PATH;
            else t.tag = TAG_METHOD;
          end
          PH_PATH: begin
            if (b == CH_SP) phase = PH_PROTO;
            else t.tag = TAG_PATH;
          end
          PH_PROTO: begin
            if (b == CH_LF) phase = PH_NAME;
            else if (b != CH_CR) t.tag = TAG_PROTO;
          end
          PH_NAME: begin
            if (b == CH_LF) begin
              t.head_end = 1'b1;
              done       = 1'b1;
            end else if (b == CH_COLON) begin
              phase      = PH_VALUE;
              skip_space = 1'b1;
            end else if (b != CH_CR) begin
              t.tag     = TAG_NAME;
              name_seen = 1'b1;
            end
          end
          PH_VALUE: begin
            if (skip_now && b == CH_SP) begin
              // single space after the colon
            end else if (b == CH_LF) begin
              if (!name_seen && !value_seen) begin
                t.head_end = 1'b1;
                done       = 1'b1;
              end else begin
                t.pair_end = 1'b1;
                name_seen  = 1'b0;
                value_seen = 1'b0;
                phase      = PH_NAME;
              end
            end else if (b != CH_CR) begin
              t.tag      = TAG_VALUE;
              value_seen = 1'b1;
            end
          end
          default: ;
        endcase
      end
      expected_q.push_back(t);
    endfunction

    function void flag(string what, token_t want, token_t got);
      n_errors++;
      if (n_errors <= 10)
        $display("%0t ERROR %s: exp byte=%02h tag=%0d pe=%0b he=%0b, got byte=%02h tag=%0d pe=%0b he=%0b",
                 $time, what, want.data, want.tag, want.pair_end, want.head_end,
                 got.data, got.tag, got.pair_end, got.head_end);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_q.size() == 0) begin
        want = '0;
        flag("result with nothing expected", want, got);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (want.pair_end) n_pairs++;
      if (want.head_end) n_heads++;
      if (got.data !== want.data || got.tag !== want.tag ||
          got.pair_end !== want.pair_end || got.head_end !== want.head_end)
        flag("token mismatch", want, got);
    endfunction
  endclass

  localparam int unsigned RandomBytes = 1600;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrht_in_if  in_if ();
  hrht_out_if out_if ();

  http_request_head_tokenizer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  head_token_scoreboard sb;
  logic [8:0]  stim_q[$];
  int unsigned burst_left = 0;
  int unsigned n_sent = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_cyc = 0;

  // Receiver back-pressure, switching at random between open, coin, slow and periodic patterns.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_if.ready <= 1'b1;
      RX_COIN:     out_if.ready <= 1'($urandom_range(0, 1));
      RX_SLOW:     out_if.ready <= ($urandom_range(0, 4) == 0);
      RX_PERIODIC: out_if.ready <= ((rx_cyc % 8) < 3);
      default:     out_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    token_t got;
    got.data     = out_if.out_byte;
    got.tag      = out_if.tag;
    got.pair_end = out_if.pair_end;
    got.head_end = out_if.head_end;
    if (rst_ni && out_if.valid && out_if.ready) sb.check_token(got);
  end

  function automatic void push_byte(logic [7:0] b, bit f);
    stim_q.push_back({f, b});
  endfunction

  function automatic void push_text(string s, bit f);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], f && i == 0);
  endfunction

  function automatic logic [7:0] rand_text(bit allow_colon, bit allow_space);
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(1, 255));
    else if (allow_space && $urandom_range(0, 6) == 0) c = CH_SP;
    else c = 8'($urandom_range(33, 126));
    if (!allow_colon && c == CH_COLON) c = "_";
    return c;
  endfunction

  // One request head, mostly well formed, now and then cut short or damaged.
  function automatic void gen_head();
    int unsigned n;
    int unsigned r;
    int unsigned idx;
    stim_q.delete();
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push_byte(rand_text(1, 0), i == 0);
    push_byte(CH_SP, 0);
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) push_byte(rand_text(1, 0), 0);
    push_byte(CH_SP, 0);
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) push_byte(rand_text(1, 0), 0);
    if ($urandom_range(0, 4) != 0) push_byte(CH_CR, 0);
    push_byte(CH_LF, 0);
    for (int h = $urandom_range(0, 5); h > 0; h--) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_byte(rand_text(0, 0), 0);
      if ($urandom_range(0, 19) == 0) push_byte(CH_CR, 0);
      push_byte(CH_COLON, 0);
      if ($urandom_range(0, 9) < 7) push_byte(CH_SP, 0);
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) push_byte(rand_text(1, 1), 0);
      if ($urandom_range(0, 4) != 0) push_byte(CH_CR, 0);
      push_byte(CH_LF, 0);
    end
    r = $urandom_range(0, 19);
    if (r < 14) begin
      push_byte(CH_CR, 0);
      push_byte(CH_LF, 0);
    end else if (r < 17) begin
      push_byte(CH_LF, 0);
    end else begin
      push_byte(CH_NUL, 0);
    end
    for (int i = $urandom_range(0, 2); i > 0; i--) push_byte(rand_text(1, 1), 0);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      idx = $urandom_range(1, stim_q.size() - 1);
      while (stim_q.size() > idx) void'(stim_q.pop_back());
    end else if (r == 1) begin
      idx = $urandom_range(1, stim_q.size() - 1);
      stim_q[idx] = {1'b0, 8'($urandom_range(0, 255))};
    end else if (r == 2) begin
      stim_q[0][8] = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 24);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.first   <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_byte(b, f);
    n_sent++;
    burst_left--;
  endtask

  task automatic send_all();
    while (stim_q.size() != 0) begin
      logic [8:0] s;
      s = stim_q.pop_front();
      send_byte(s[7:0], s[8]);
    end
  endtask

  // Hold the sender off until every pending token has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  initial begin
    int unsigned target;
    bit          mid_drained;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    in_if.first   = 1'b0;
    mid_drained   = 1'b0;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: full line set, colon without space, empty pair, ignored byte,
    // top byte value, NUL, line feed after a partial name
    push_text("G / H\r\n", 1);
    push_text("N: v\r\n", 0);
    push_text("k:v\n", 0);
    push_text(":\n", 0);
    push_text("x", 0);
    push_byte(8'hFF, 1);
    push_byte(CH_NUL, 0);
    push_text("A B C\nq\n", 1);
    send_all();
    drain();

    target = n_sent + RandomBytes;
    while (n_sent < target) begin
      gen_head();
      send_all();
      if (!mid_drained && n_sent > target - RandomBytes / 2) begin
        drain();
        mid_drained = 1'b1;
      end
    end
    drain();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d request bytes; checked %0d tokens, %0d pair ends, %0d head ends.",
             n_sent, sb.n_checked, sb.n_pairs, sb.n_heads);
    $display("Mismatches or unexpected results: %0d", sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d tokens outstanding", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
